// ===== hdl/bmp_rle8_run_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while reset is held low.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE8_RUN_DECODER_CORE_DEFINES_SVH
`define BMP_RLE8_RUN_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define BMP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp rle8 decoder: same-cycle check failed");

// next-cycle implication
`define BMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp rle8 decoder: next-cycle check failed");

`endif

// ===== hdl/bmprle_pkg.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder package
// Parser modes, result kinds, register indexes and controller interface types.
// ----------------------------------------------------------------------------
package bmprle_pkg;

    typedef enum logic [3:0] {
        MODE_COUNT,
        MODE_ESCAPE,
        MODE_DX,
        MODE_DY,
        MODE_VALUE,
        MODE_LITERAL,
        MODE_PAD,
        MODE_ENDED,
        MODE_FAULT
    } mode_t;

    localparam logic [1:0] KIND_CODED = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [7:0] CFG_ROW_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_FILL_VALUE = 8'd1;

    localparam logic [15:0] ROW_WIDTH_RESET = 16'd640;
    localparam logic [15:0] FILL_RESET      = 16'hFFFF;
    localparam logic [16:0] FULL_ROW        = 17'h10000;

    localparam int MOD_RADIX_BITS = 4;
    localparam int MOD_STEPS      = 5;
    localparam int MOD_DIV_BITS   = MOD_RADIX_BITS * MOD_STEPS;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MUL,
        C_EVAL,
        C_MOD,
        C_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic eval_en;
        logic mod_step;
        logic commit_col;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic res_pending;
        logic out_free;
    } sts_t;

endpackage

// ===== hdl/bmprle_mod.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 column remainder unit
// Radix-16 restoring remainder of a 17-bit column sum by the row width.
// ----------------------------------------------------------------------------
module bmprle_mod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        step,
    input  logic [16:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);
    import bmprle_pkg::*;

    localparam int CNT_W = $clog2(MOD_STEPS + 1);

    logic [MOD_DIV_BITS-1:0] div_reg, div_next;
    logic [15:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    always_comb begin
        logic [15:0] r;
        logic [16:0] t;
        r = rem_reg;
        for (int i = 0; i < MOD_RADIX_BITS; i++) begin
            t = {r, div_reg[MOD_DIV_BITS-1-i]};
            if (t >= divisor) begin
                t = t - divisor;
            end
            r = t[15:0];
        end
        rem_next = r;
        div_next = div_reg << MOD_RADIX_BITS;
        cnt_next = cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_W'(MOD_STEPS);
        end else if (start) begin
            cnt_reg <= '0;
        end else if (step && !done) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            div_reg <= MOD_DIV_BITS'(dividend);
        end else if (step && !done) begin
            rem_reg <= rem_next;
            div_reg <= div_next;
        end
    end

    assign done      = (cnt_reg == CNT_W'(MOD_STEPS));
    assign remainder = rem_reg;

endmodule

// ===== hdl/bmprle_dpath.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder datapath
// Configuration registers, parser state, run evaluation and result register.
// ----------------------------------------------------------------------------
`include "bmp_rle8_run_decoder_core_defines.svh"

module bmprle_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  bmprle_pkg::cmd_t  cmd,
    output bmprle_pkg::sts_t  sts,
    input  logic [7:0]        s_data_byte,
    input  logic              s_image_start,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [15:0]       m_pixel,
    output logic [23:0]       m_run_length,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import bmprle_pkg::*;

    logic [15:0] row_width_reg, fill_value_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic [23:0] prod_reg;

    mode_t       mode_reg, mode_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  dx_reg, dx_next;
    logic [15:0] col_reg;
    logic        row_done_reg;
    logic        odd_reg, odd_next;

    logic        res_pending_reg, res_pending_next;
    logic [1:0]  res_kind_reg, res_kind_next;
    logic [15:0] res_pixel_reg, res_pixel_next;
    logic [23:0] res_len_reg, res_len_next;
    logic        adv_reg, adv_next;
    logic [16:0] mod_x;

    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [15:0] m_pixel_reg;
    logic [23:0] m_len_reg;

    logic [16:0] width_now;
    mode_t       eff_mode;
    logic [7:0]  eff_pend, eff_dx;
    logic [15:0] eff_col;
    logic        eff_done, eff_odd;
    logic [16:0] col_plus_pend, col_plus_dx, col_plus_one;
    logic [23:0] fill_len, dy_sum, dy_len;
    logic [7:0]  pend_dec;
    logic        mod_done;
    logic [15:0] mod_rem;

    assign width_now = (row_width_reg == 16'd0) ? FULL_ROW : {1'b0, row_width_reg};
    assign cfg_ready = 1'b1;

    always_comb begin
        if (start_reg) begin
            eff_mode = MODE_COUNT;
            eff_pend = '0;
            eff_dx   = '0;
            eff_col  = '0;
            eff_done = 1'b0;
            eff_odd  = 1'b0;
        end else begin
            eff_mode = mode_reg;
            eff_pend = pend_reg;
            eff_dx   = dx_reg;
            eff_col  = col_reg;
            eff_done = row_done_reg;
            eff_odd  = odd_reg;
        end
    end

    assign col_plus_pend = {1'b0, eff_col} + {9'd0, eff_pend};
    assign col_plus_dx   = {1'b0, eff_col} + {9'd0, eff_dx};
    assign col_plus_one  = {1'b0, eff_col} + 17'd1;
    assign fill_len      = {7'd0, width_now} - {8'd0, eff_col};
    assign dy_sum        = prod_reg + {16'd0, eff_dx};
    assign dy_len        = dy_sum - {8'd0, eff_col};
    assign pend_dec      = (eff_pend != 8'd0) ? eff_pend - 8'd1 : 8'd0;

    always_comb begin
        mode_next        = eff_mode;
        pend_next        = eff_pend;
        dx_next          = eff_dx;
        odd_next         = eff_odd;
        res_pending_next = 1'b0;
        res_kind_next    = KIND_CODED;
        res_pixel_next   = '0;
        res_len_next     = '0;
        adv_next         = 1'b0;
        mod_x            = '0;
        unique case (eff_mode)
            MODE_COUNT: begin
                if (byte_reg == 8'd0) begin
                    mode_next = MODE_ESCAPE;
                end else begin
                    pend_next = byte_reg;
                    mode_next = MODE_VALUE;
                end
            end
            MODE_VALUE: begin
                pend_next        = '0;
                mode_next        = MODE_COUNT;
                adv_next         = (eff_pend != 8'd0);
                mod_x            = col_plus_pend;
                res_pending_next = 1'b1;
                res_kind_next    = KIND_CODED;
                res_pixel_next   = {8'd0, byte_reg};
                res_len_next     = {16'd0, eff_pend};
            end
            MODE_ESCAPE: begin
                if (byte_reg == 8'd0) begin
                    mode_next = MODE_COUNT;
                    if (!eff_done) begin
                        adv_next         = (fill_len != 24'd0);
                        res_pending_next = 1'b1;
                        res_kind_next    = KIND_FILL;
                        res_pixel_next   = fill_value_reg;
                        res_len_next     = fill_len;
                    end
                end else if (byte_reg == 8'd1) begin
                    mode_next        = MODE_ENDED;
                    res_pending_next = 1'b1;
                    res_kind_next    = KIND_END;
                end else if (byte_reg == 8'd2) begin
                    mode_next = MODE_DX;
                end else begin
                    pend_next = byte_reg;
                    odd_next  = byte_reg[0];
                    mode_next = MODE_LITERAL;
                end
            end
            MODE_DX: begin
                dx_next   = byte_reg;
                mode_next = MODE_DY;
            end
            MODE_DY: begin
                mode_next = MODE_COUNT;
                dx_next   = '0;
                if (byte_reg == 8'd0) begin
                    mod_x = col_plus_dx;
                    if (eff_dx != 8'd0) begin
                        adv_next         = 1'b1;
                        res_pending_next = 1'b1;
                        res_kind_next    = KIND_FILL;
                        res_pixel_next   = fill_value_reg;
                        res_len_next     = {16'd0, eff_dx};
                    end
                end else begin
                    mod_x = {9'd0, eff_dx};
                    if (dy_len != 24'd0) begin
                        adv_next         = 1'b1;
                        res_pending_next = 1'b1;
                        res_kind_next    = KIND_FILL;
                        res_pixel_next   = fill_value_reg;
                        res_len_next     = dy_len;
                    end
                end
            end
            MODE_LITERAL: begin
                pend_next = pend_dec;
                if (pend_dec == 8'd0) begin
                    mode_next = eff_odd ? MODE_PAD : MODE_COUNT;
                end
                adv_next         = 1'b1;
                mod_x            = col_plus_one;
                res_pending_next = 1'b1;
                res_kind_next    = KIND_CODED;
                res_pixel_next   = {8'd0, byte_reg};
                res_len_next     = 24'd1;
            end
            MODE_PAD: begin
                odd_next = 1'b0;
                if (byte_reg != 8'd0) begin
                    mode_next        = MODE_FAULT;
                    res_pending_next = 1'b1;
                    res_kind_next    = KIND_ERROR;
                end else begin
                    mode_next = MODE_COUNT;
                end
            end
            default: begin
            end
        endcase
    end

    bmprle_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.eval_en),
        .step      (cmd.mod_step),
        .dividend  (mod_x),
        .divisor   (width_now),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg  <= ROW_WIDTH_RESET;
            fill_value_reg <= FILL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ROW_WIDTH) begin
                row_width_reg <= cfg_data;
            end else if (cfg_index == CFG_FILL_VALUE) begin
                fill_value_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            byte_reg  <= s_data_byte;
        end
        if (cmd.mul_en) begin
            prod_reg <= 24'({7'd0, width_now} * {16'd0, byte_reg});
        end
        if (cmd.eval_en) begin
            res_kind_reg  <= res_kind_next;
            res_pixel_reg <= res_pixel_next;
            res_len_reg   <= res_len_next;
        end
        if (cmd.out_load) begin
            m_kind_reg  <= res_kind_reg;
            m_pixel_reg <= res_pixel_reg;
            m_len_reg   <= res_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg       <= 1'b0;
            mode_reg        <= MODE_COUNT;
            pend_reg        <= '0;
            dx_reg          <= '0;
            col_reg         <= '0;
            row_done_reg    <= 1'b0;
            odd_reg         <= 1'b0;
            res_pending_reg <= 1'b0;
            adv_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.capture) begin
                start_reg <= s_image_start;
            end
            if (cmd.eval_en) begin
                mode_reg        <= mode_next;
                pend_reg        <= pend_next;
                dx_reg          <= dx_next;
                odd_reg         <= odd_next;
                col_reg         <= eff_col;
                row_done_reg    <= eff_done;
                res_pending_reg <= res_pending_next;
                adv_reg         <= adv_next;
            end
            if (cmd.commit_col && adv_reg) begin
                col_reg      <= mod_rem;
                row_done_reg <= (mod_rem == 16'd0);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.mod_done    = mod_done;
    assign sts.res_pending = res_pending_reg;
    assign sts.out_free    = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_pixel      = m_pixel_reg;
    assign m_run_length = m_len_reg;

    `BMP_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `BMP_ASSERT_NEXT(a_end_mode, aclk, aresetn,
        cmd.eval_en && res_pending_next && res_kind_next == KIND_END, mode_reg == MODE_ENDED)
    `BMP_ASSERT_NEXT(a_mode_hold, aclk, aresetn, !cmd.eval_en, $stable(mode_reg))

endmodule

// ===== hdl/bmprle_ctrl.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder controller
// Sequences capture, multiply, evaluate, column remainder and result handoff.
// ----------------------------------------------------------------------------
`include "bmp_rle8_run_decoder_core_defines.svh"

module bmprle_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmprle_pkg::sts_t  sts,
    output bmprle_pkg::cmd_t  cmd
);
    import bmprle_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (s_valid) begin
                    state_next = C_MUL;
                end
            end
            C_MUL:  state_next = C_EVAL;
            C_EVAL: state_next = C_MOD;
            C_MOD: begin
                if (sts.mod_done) begin
                    state_next = C_EMIT;
                end
            end
            C_EMIT: begin
                if (!sts.res_pending || sts.out_free) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            C_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            C_MUL:  cmd.mul_en  = 1'b1;
            C_EVAL: cmd.eval_en = 1'b1;
            C_MOD: begin
                cmd.mod_step   = !sts.mod_done;
                cmd.commit_col = sts.mod_done;
            end
            C_EMIT: cmd.out_load = sts.res_pending && sts.out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `BMP_ASSERT_NEXT(a_accept_mul, aclk, aresetn, s_valid && s_ready, state_reg == C_MUL)
    `BMP_ASSERT_NEXT(a_eval_mod, aclk, aresetn, cmd.eval_en, state_reg == C_MOD && !sts.mod_done)
    `BMP_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, !cmd.mod_step && !cmd.eval_en)

endmodule

// ===== hdl/bmp_rle8_run_decoder_core.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder core
// Decodes an RLE8 compressed byte stream into coded, fill, end and error runs.
//
//   port group   dir   handshake          payload
//   s_           in    s_valid/s_ready    data_byte, image_start
//   m_           out   m_valid/m_ready    kind, pixel, run_length
//   cfg_         in    cfg_valid/ready    cfg_index, cfg_data
//
// Each byte is taken only after the last is through its steps: capture,
// width-times-dy multiply, evaluate, five radix-16 steps of the column
// remainder by the row width, column commit, then load of a pending result.
// The output register lets the next byte be accepted while a result waits;
// the load stalls while an earlier result is still held at the output.
// Synchronous active-low reset; no clearing pass. Config writes always ready.
// ----------------------------------------------------------------------------
module bmp_rle8_run_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_image_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [15:0] m_pixel,
    output logic [23:0] m_run_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import bmprle_pkg::*;

    cmd_t cmd;
    sts_t sts;

    bmprle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bmprle_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_data_byte   (s_data_byte),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_pixel       (m_pixel),
        .m_run_length  (m_run_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

// ===== dv/bmp_rle8_run_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// BMP RLE8 run decoder core testbench
// Streams directed and random RLE8 images into the decoder under random
// input gaps and output stalls, and several row width and fill settings.
// A local parser tracks the decoder state and predicts every run. Each run
// the decoder hands off is checked in order against that prediction.
// ----------------------------------------------------------------------------
module bmp_rle8_run_decoder_core_test;
    import bmprle_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pixel;
        logic [23:0] len;
    } run_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_image_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [15:0] m_pixel;
    logic [23:0] m_run_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [15:0] cfg_data = 16'h0000;

    req_t  byte_q[$];
    run_t  runs_due[$];
    int    n_queued = 0;
    int    errors = 0;
    int    cycles = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    int    in_idle_pct = 20;
    int    out_idle_pct = 20;
    bit    req_taken = 1'b0;
    logic  start_pending = 1'b0;
    req_t  next_req;
    run_t  want;

    // parser image
    mode_t       pmode = MODE_COUNT;
    logic [7:0]  pend_cnt = 8'h00;
    logic [7:0]  dx_hold = 8'h00;
    logic [15:0] col = 16'h0000;
    logic        row_end = 1'b0;
    logic        odd_lit = 1'b0;
    logic [15:0] row_w = ROW_WIDTH_RESET;
    logic [15:0] fill_v = FILL_RESET;

    bmp_rle8_run_decoder_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_image_start (s_image_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_pixel       (m_pixel),
        .m_run_length  (m_run_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned span();
        return (row_w == 16'd0) ? 32'(FULL_ROW) : 32'(row_w);
    endfunction

    task automatic log_run(input logic [1:0] k, input logic [15:0] p, input int unsigned n);
        run_t r;
        r.kind  = k;
        r.pixel = p;
        r.len   = n[23:0];
        runs_due.push_back(r);
    endtask

    task automatic move_col(input int unsigned n);
        int unsigned sum;
        if (n != 0) begin
            sum = 32'(col) + n;
            col = 16'(sum % span());
            row_end = (col == 16'd0);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic st);
        int unsigned n;
        int unsigned w;
        if (st) begin
            pmode = MODE_COUNT;
            pend_cnt = 8'h00;
            dx_hold = 8'h00;
            col = 16'h0000;
            row_end = 1'b0;
            odd_lit = 1'b0;
        end
        w = span();
        case (pmode)
            MODE_COUNT: begin
                if (b == 8'd0) begin
                    pmode = MODE_ESCAPE;
                end else begin
                    pend_cnt = b;
                    pmode = MODE_VALUE;
                end
            end
            MODE_VALUE: begin
                n = 32'(pend_cnt);
                pend_cnt = 8'h00;
                pmode = MODE_COUNT;
                move_col(n);
                log_run(KIND_CODED, {8'h00, b}, n);
            end
            MODE_ESCAPE: begin
                if (b == 8'd0) begin
                    pmode = MODE_COUNT;
                    if (!row_end) begin
                        n = w - 32'(col);
                        move_col(n);
                        log_run(KIND_FILL, fill_v, n);
                    end
                end else if (b == 8'd1) begin
                    pmode = MODE_ENDED;
                    log_run(KIND_END, 16'h0000, 0);
                end else if (b == 8'd2) begin
                    pmode = MODE_DX;
                end else begin
                    pend_cnt = b;
                    odd_lit = b[0];
                    pmode = MODE_LITERAL;
                end
            end
            MODE_DX: begin
                dx_hold = b;
                pmode = MODE_DY;
            end
            MODE_DY: begin
                pmode = MODE_COUNT;
                if (b == 8'd0) n = 32'(dx_hold);
                else n = w * 32'(b) - 32'(col) + 32'(dx_hold);
                dx_hold = 8'h00;
                if (n != 0) begin
                    move_col(n);
                    log_run(KIND_FILL, fill_v, n);
                end
            end
            MODE_LITERAL: begin
                if (pend_cnt != 8'd0) pend_cnt = pend_cnt - 8'd1;
                if (pend_cnt == 8'd0) pmode = odd_lit ? MODE_PAD : MODE_COUNT;
                move_col(1);
                log_run(KIND_CODED, {8'h00, b}, 1);
            end
            MODE_PAD: begin
                odd_lit = 1'b0;
                if (b != 8'd0) begin
                    pmode = MODE_FAULT;
                    log_run(KIND_ERROR, 16'h0000, 0);
                end else begin
                    pmode = MODE_COUNT;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_req(input logic [7:0] b, input logic st);
        req_t r;
        r.start = st;
        r.data  = b;
        byte_q.push_back(r);
        n_queued++;
    endtask

    task automatic put(input logic [7:0] b);
        add_req(b, start_pending);
        start_pending = 1'b0;
    endtask

    task automatic build_images(input int target);
        int   stop;
        int   ops;
        int   r;
        int   n;
        int   k;
        logic done;
        stop = n_queued + target;
        while (n_queued < stop) begin
            ops = $urandom_range(4, 40);
            start_pending = 1'b1;
            done = 1'b0;
            for (k = 0; k < ops && !done; k++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    put(8'(($urandom_range(0, 99) < 60) ? $urandom_range(1, 8)
                                                        : $urandom_range(1, 255)));
                    put(8'($urandom_range(0, 255)));
                end else if (r < 57) begin
                    put(8'd0);
                    put(8'd0);
                end else if (r < 69) begin
                    put(8'd0);
                    put(8'd2);
                    put(8'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255)));
                    n = $urandom_range(0, 99);
                    put(8'((n < 50) ? 0 : (n < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(0, 255)));
                end else if (r < 90) begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255)
                                                    : $urandom_range(3, 12);
                    put(8'd0);
                    put(8'(n));
                    repeat (n) put(8'($urandom_range(0, 255)));
                    if (n % 2 == 1) begin
                        if ($urandom_range(0, 19) == 0) begin
                            put(8'($urandom_range(1, 255)));
                            done = 1'b1;
                        end else begin
                            put(8'd0);
                        end
                    end
                end else if (r < 95) begin
                    add_req(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                end else if (r < 97) begin
                    put(8'd0);
                    put(8'd1);
                    done = 1'b1;
                end else begin
                    put(8'd0);
                    if ($urandom_range(0, 1) == 1) put(8'd2);
                    done = 1'b1;
                end
            end
            if (!done) begin
                put(8'd0);
                put(8'd1);
            end
            repeat ($urandom_range(0, 2)) add_req(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic drain(input int tail);
        do @(posedge aclk);
        while (byte_q.size() != 0 || s_valid || runs_due.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == CFG_ROW_WIDTH) row_w = val;
        else if (idx == CFG_FILL_VALUE) fill_v = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] w, input logic [15:0] f, input int n,
                             input int in_pct, input int out_pct);
        write_reg(CFG_ROW_WIDTH, w);
        write_reg(CFG_FILL_VALUE, f);
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        build_images(n);
        drain(TAIL_CYCLES);
    endtask

    // request side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (req_taken) begin
                req_taken = 1'b0;
                gap_left = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                next_req = byte_q.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= next_req.data;
                s_image_start <= next_req.start;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            decode_byte(s_data_byte, s_image_start);
            req_taken = 1'b1;
        end
    end

    // result side
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < out_idle_pct) hold_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run kind=%0d pixel=%h length=%0d",
                         $time, m_kind, m_pixel, m_run_length);
                errors++;
            end else begin
                want = runs_due.pop_front();
                if (m_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_kind);
                    errors++;
                end
                if (m_pixel !== want.pixel) begin
                    $display("%0t: pixel expected %h actual %h", $time, want.pixel, m_pixel);
                    errors++;
                end
                if (m_run_length !== want.len) begin
                    $display("%0t: run_length expected %0d actual %0d",
                             $time, want.len, m_run_length);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // full row at image start, then nothing at a completed row, then a long coded run
        add_req(8'd0, 1'b1);
        add_req(8'd0, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd255, 1'b0);
        add_req(8'hFF, 1'b0);
        // delta with dy zero, empty delta, widest delta
        add_req(8'd0, 1'b0);
        add_req(8'd2, 1'b0);
        add_req(8'd5, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd2, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd0, 1'b0);
        add_req(8'd2, 1'b0);
        add_req(8'd255, 1'b0);
        add_req(8'd255, 1'b0);
        // odd literal with a bad pad, then an ignored byte
        add_req(8'd0, 1'b0);
        add_req(8'd3, 1'b0);
        add_req(8'h01, 1'b0);
        add_req(8'h80, 1'b0);
        add_req(8'h7F, 1'b0);
        add_req(8'hA5, 1'b0);
        add_req(8'd9, 1'b0);
        // end of bitmap, then ignored byte
        add_req(8'd0, 1'b1);
        add_req(8'd1, 1'b0);
        add_req(8'd200, 1'b0);
        drain(TAIL_CYCLES);

        run_phase(16'd1, 16'h0000, 250, 30, 30);
        run_phase(16'hFFFF, 16'hFFFF, 250, 30, 30);
        run_phase(16'd2, 16'($urandom_range(0, 65535)), 200, 0, 0);
        run_phase(16'($urandom_range(3, 16)), 16'($urandom_range(0, 65535)), 250, 60, 60);
        run_phase(16'($urandom_range(17, 700)), 16'($urandom_range(0, 65535)), 200, 20, 50);
        run_phase(ROW_WIDTH_RESET, 16'($urandom_range(0, 65535)), 200, 50, 10);

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
